### src/bcu_pkg.sv
// shared types, widths and the division step helper for the barycentric coverage unit
package bcu_pkg;

   localparam int COORD_FRAC_BITS  = 4;
   localparam int WEIGHT_FRAC_BITS = 16;

   localparam int PIX_W = 12;
   localparam int CRD_W = 20;
   localparam int DW_W  = 24;
   localparam int FH_W  = 13;
   localparam int WT_W  = WEIGHT_FRAC_BITS + 1;

   // pixel position scaled to coordinate units
   localparam int PXS_W = PIX_W + COORD_FRAC_BITS;
   localparam int DIF_W = ((CRD_W > PXS_W + 1) ? CRD_W : PXS_W + 1) + 1;
   localparam int PRD_W = 2 * DIF_W;
   localparam int CRS_W = PRD_W + 1;
   localparam int SUM_W = CRS_W + 1;
   localparam int DP_W  = WT_W + 1 + DW_W;
   localparam int DS_W  = DP_W + 2;

   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(1080);
   localparam logic [WT_W-1:0] WEIGHT_ONE       = WT_W'(1) << WEIGHT_FRAC_BITS;
   localparam logic signed [DW_W-1:0] DEPTH_MAX = {1'b0, {(DW_W-1){1'b1}}};
   localparam logic signed [DW_W-1:0] DEPTH_MIN = {1'b1, {(DW_W-1){1'b0}}};

   typedef struct packed {
      logic        [PIX_W-1:0] pixel_x;
      logic        [PIX_W-1:0] pixel_y;
      logic signed [CRD_W-1:0] vertex_a_x;
      logic signed [CRD_W-1:0] vertex_a_y;
      logic signed [DW_W-1:0]  vertex_a_w;
      logic signed [CRD_W-1:0] vertex_b_x;
      logic signed [CRD_W-1:0] vertex_b_y;
      logic signed [DW_W-1:0]  vertex_b_w;
      logic signed [CRD_W-1:0] vertex_c_x;
      logic signed [CRD_W-1:0] vertex_c_y;
      logic signed [DW_W-1:0]  vertex_c_w;
   } req_type;

   typedef struct packed {
      logic                    covered;
      logic        [WT_W-1:0]  weight_a;
      logic        [WT_W-1:0]  weight_b;
      logic        [WT_W-1:0]  weight_c;
      logic signed [DW_W-1:0]  depth_value;
      logic        [PIX_W-1:0] out_column;
      logic        [PIX_W-1:0] out_row;
   } rsp_type;

   // values carried alongside the arithmetic
   typedef struct packed {
      logic signed [DW_W-1:0]  wa;
      logic signed [DW_W-1:0]  wb;
      logic signed [DW_W-1:0]  wc;
      logic        [PIX_W-1:0] column;
      logic        [PIX_W-1:0] row;
   } side_type;

   // one restoring division step: {quotient bit, new remainder}, remainder < divisor
   function automatic logic [CRS_W:0] div_step(input logic [CRS_W-1:0] rem,
                                               input logic [CRS_W-1:0] dvs);
      logic [CRS_W:0] shifted;
      logic [CRS_W:0] diff;
      logic           ge;
      shifted = {rem, 1'b0};
      diff    = shifted - {1'b0, dvs};
      ge      = (shifted >= {1'b0, dvs});
      return ge ? {1'b1, diff[CRS_W-1:0]} : {1'b0, shifted[CRS_W-1:0]};
   endfunction

endpackage

### src/bcu_if.sv
// handshake channels for request and response items
interface bcu_req_if import bcu_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bcu_rsp_if import bcu_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### src/bcu_setup.sv
// edge vectors, cross products, coverage decision and magnitudes
module bcu_setup import bcu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  req_type          in_data,
   input  logic [FH_W-1:0]  frame_height,
   output logic             out_valid,
   output logic             out_cov,
   output logic [CRS_W-1:0] out_mag_u,
   output logic [CRS_W-1:0] out_mag_v,
   output logic [CRS_W-1:0] out_mag_d,
   output side_type         out_side
);

   logic [3:0] valid_ff;

   // stage 1
   logic signed [DIF_W-1:0] acx_ff, acy_ff, abx_ff, aby_ff, apx_ff, apy_ff;
   logic signed [DIF_W-1:0] px_s, py_s;
   side_type                side1_in, side1_ff, side2_ff, side3_ff, side4_ff;
   logic [FH_W-1:0]         row_full;

   // stage 2
   logic signed [PRD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;

   // stage 3
   logic signed [CRS_W-1:0] d_ff, u_ff, v_ff;

   // stage 4
   logic signed [SUM_W-1:0] uv_sum, d_ext;
   logic                    cov_in, cov_ff;
   logic [CRS_W-1:0]        mag_u_ff, mag_v_ff, mag_d_ff;

   assign px_s = $signed({{(DIF_W-PIX_W){1'b0}}, in_data.pixel_x}) <<< COORD_FRAC_BITS;
   assign py_s = $signed({{(DIF_W-PIX_W){1'b0}}, in_data.pixel_y}) <<< COORD_FRAC_BITS;

   always_comb begin
      row_full        = frame_height - FH_W'(1) - FH_W'(in_data.pixel_y);
      side1_in.wa     = in_data.vertex_a_w;
      side1_in.wb     = in_data.vertex_b_w;
      side1_in.wc     = in_data.vertex_c_w;
      side1_in.column = in_data.pixel_x;
      side1_in.row    = row_full[PIX_W-1:0];
   end

   always_comb begin
      uv_sum = SUM_W'(u_ff) + SUM_W'(v_ff);
      d_ext  = SUM_W'(d_ff);
      if (d_ff > 0) begin
         cov_in = (u_ff >= 0) && (v_ff >= 0) && (uv_sum < d_ext);
      end else if (d_ff < 0) begin
         cov_in = (u_ff <= 0) && (v_ff <= 0) && (uv_sum > d_ext);
      end else begin
         cov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acx_ff   <= DIF_W'(in_data.vertex_c_x) - DIF_W'(in_data.vertex_a_x);
         acy_ff   <= DIF_W'(in_data.vertex_c_y) - DIF_W'(in_data.vertex_a_y);
         abx_ff   <= DIF_W'(in_data.vertex_b_x) - DIF_W'(in_data.vertex_a_x);
         aby_ff   <= DIF_W'(in_data.vertex_b_y) - DIF_W'(in_data.vertex_a_y);
         apx_ff   <= px_s - DIF_W'(in_data.vertex_a_x);
         apy_ff   <= py_s - DIF_W'(in_data.vertex_a_y);
         side1_ff <= side1_in;

         p0_ff    <= acx_ff * aby_ff;
         p1_ff    <= acy_ff * abx_ff;
         p2_ff    <= apx_ff * aby_ff;
         p3_ff    <= apy_ff * abx_ff;
         p4_ff    <= acx_ff * apy_ff;
         p5_ff    <= acy_ff * apx_ff;
         side2_ff <= side1_ff;

         d_ff     <= CRS_W'(p0_ff) - CRS_W'(p1_ff);
         u_ff     <= CRS_W'(p2_ff) - CRS_W'(p3_ff);
         v_ff     <= CRS_W'(p4_ff) - CRS_W'(p5_ff);
         side3_ff <= side2_ff;

         cov_ff   <= cov_in;
         mag_u_ff <= (u_ff < 0) ? CRS_W'(-u_ff) : CRS_W'(u_ff);
         mag_v_ff <= (v_ff < 0) ? CRS_W'(-v_ff) : CRS_W'(v_ff);
         mag_d_ff <= (d_ff < 0) ? CRS_W'(-d_ff) : CRS_W'(d_ff);
         side4_ff <= side3_ff;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_cov   = cov_ff;
   assign out_mag_u = mag_u_ff;
   assign out_mag_v = mag_v_ff;
   assign out_mag_d = mag_d_ff;
   assign out_side  = side4_ff;

endmodule

### src/bcu_div.sv
// pipelined restoring divider, one quotient bit per stage for both weights
module bcu_div import bcu_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic                        in_cov,
   input  logic [CRS_W-1:0]            in_num_b,
   input  logic [CRS_W-1:0]            in_num_c,
   input  logic [CRS_W-1:0]            in_den,
   input  side_type                    in_side,
   output logic                        out_valid,
   output logic                        out_cov,
   output logic [WEIGHT_FRAC_BITS-1:0] out_q_b,
   output logic [WEIGHT_FRAC_BITS-1:0] out_q_c,
   output side_type                    out_side
);

   localparam int N = WEIGHT_FRAC_BITS;

   logic                 valid_ff [N];
   logic                 cov_ff   [N];
   logic [CRS_W-1:0]     rb_ff    [N];
   logic [CRS_W-1:0]     rc_ff    [N];
   logic [CRS_W-1:0]     den_ff   [N];
   logic [N-1:0]         qb_ff    [N];
   logic [N-1:0]         qc_ff    [N];
   side_type             side_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic             valid_prev, cov_prev;
      logic [CRS_W-1:0] rb_prev, rc_prev, den_prev;
      logic [N-1:0]     qb_prev, qc_prev;
      side_type         side_prev;
      logic [CRS_W:0]   step_b, step_c;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign cov_prev   = in_cov;
         assign rb_prev    = in_num_b;
         assign rc_prev    = in_num_c;
         assign den_prev   = in_den;
         assign qb_prev    = '0;
         assign qc_prev    = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign cov_prev   = cov_ff[k-1];
         assign rb_prev    = rb_ff[k-1];
         assign rc_prev    = rc_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign qb_prev    = qb_ff[k-1];
         assign qc_prev    = qc_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      assign step_b = div_step(rb_prev, den_prev);
      assign step_c = div_step(rc_prev, den_prev);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cov_ff[k]  <= cov_prev;
            rb_ff[k]   <= step_b[CRS_W-1:0];
            rc_ff[k]   <= step_c[CRS_W-1:0];
            den_ff[k]  <= den_prev;
            qb_ff[k]   <= {qb_prev[N-2:0], step_b[CRS_W]};
            qc_ff[k]   <= {qc_prev[N-2:0], step_c[CRS_W]};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_cov   = cov_ff[N-1];
   assign out_q_b   = qb_ff[N-1];
   assign out_q_c   = qc_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

### src/bcu_depth.sv
// final weights, weighted depth sum and the output register
module bcu_depth import bcu_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic                        in_cov,
   input  logic [WEIGHT_FRAC_BITS-1:0] in_q_b,
   input  logic [WEIGHT_FRAC_BITS-1:0] in_q_c,
   input  side_type                    in_side,
   output logic                        out_valid,
   output rsp_type                     out_data
);

   logic [2:0]              valid_ff;
   logic [WT_W-1:0]         wb_ext, wc_ext, wbc_sum;
   logic [WT_W-1:0]         wa_in, wb_in, wc_in;
   logic [WT_W-1:0]         wa_ff, wb_ff, wc_ff, wa2_ff, wb2_ff, wc2_ff;
   logic                    cov_ff, cov2_ff;
   side_type                side_ff, side2_ff;
   logic signed [DP_W-1:0]  pa_ff, pb_ff, pc_ff;
   logic signed [DS_W-1:0]  dsum, dshift;
   logic signed [DW_W-1:0]  depth_in;
   rsp_type                 rsp_in, rsp_ff;

   always_comb begin
      wb_ext  = WT_W'(in_q_b);
      wc_ext  = WT_W'(in_q_c);
      wbc_sum = wb_ext + wc_ext;
      if (!in_cov) begin
         wa_in = '0;
         wb_in = '0;
         wc_in = '0;
      end else begin
         wa_in = (wbc_sum >= WEIGHT_ONE) ? '0 : WEIGHT_ONE - wbc_sum;
         wb_in = wb_ext;
         wc_in = wc_ext;
      end
   end

   // arithmetic shift gives the floor for negative sums
   always_comb begin
      dsum   = DS_W'(pa_ff) + DS_W'(pb_ff) + DS_W'(pc_ff);
      dshift = dsum >>> WEIGHT_FRAC_BITS;
      if (dshift > DS_W'(DEPTH_MAX)) begin
         depth_in = DEPTH_MAX;
      end else if (dshift < DS_W'(DEPTH_MIN)) begin
         depth_in = DEPTH_MIN;
      end else begin
         depth_in = dshift[DW_W-1:0];
      end
      rsp_in.covered     = cov2_ff;
      rsp_in.weight_a    = wa2_ff;
      rsp_in.weight_b    = wb2_ff;
      rsp_in.weight_c    = wc2_ff;
      rsp_in.depth_value = depth_in;
      rsp_in.out_column  = side2_ff.column;
      rsp_in.out_row     = side2_ff.row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wa_ff   <= wa_in;
         wb_ff   <= wb_in;
         wc_ff   <= wc_in;
         cov_ff  <= in_cov;
         side_ff <= in_side;

         pa_ff    <= $signed({1'b0, wa_ff}) * side_ff.wa;
         pb_ff    <= $signed({1'b0, wb_ff}) * side_ff.wb;
         pc_ff    <= $signed({1'b0, wc_ff}) * side_ff.wc;
         wa2_ff   <= wa_ff;
         wb2_ff   <= wb_ff;
         wc2_ff   <= wc_ff;
         cov2_ff  <= cov_ff;
         side2_ff <= side_ff;

         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = rsp_ff;

endmodule

### src/triangle_pixel_coverage_barycentric_unit.sv
// throughput: one item per cycle unless stalled; setup 4 stages, divider one stage per weight bit, depth 3
// the whole pipeline advances together and holds while a response waits on rsp ready
// reset: synchronous, active high; clears all valid bits, frame height back to 1080
// no memories, so the unit is ready to take items once reset is released
module triangle_pixel_coverage_barycentric_unit import bcu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   bcu_req_if.sink         req_chan,
   bcu_rsp_if.source       rsp_chan,
   input  logic            csr_write_en,
   input  logic [FH_W-1:0] csr_write_data
);

   logic [FH_W-1:0]             frame_height_ff;
   logic                        adv;
   logic                        su_valid, su_cov;
   logic [CRS_W-1:0]            su_mag_u, su_mag_v, su_mag_d;
   side_type                    su_side, dv_side;
   logic                        dv_valid, dv_cov;
   logic [WEIGHT_FRAC_BITS-1:0] dv_q_b, dv_q_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_write_en) begin
         frame_height_ff <= csr_write_data;
      end
   end

   assign adv            = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   bcu_setup u_setup (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_chan.valid),
      .in_data      (req_chan.data),
      .frame_height (frame_height_ff),
      .out_valid    (su_valid),
      .out_cov      (su_cov),
      .out_mag_u    (su_mag_u),
      .out_mag_v    (su_mag_v),
      .out_mag_d    (su_mag_d),
      .out_side     (su_side)
   );

   // weight of b comes from v, weight of c from u
   bcu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (su_valid),
      .in_cov    (su_cov),
      .in_num_b  (su_mag_v),
      .in_num_c  (su_mag_u),
      .in_den    (su_mag_d),
      .in_side   (su_side),
      .out_valid (dv_valid),
      .out_cov   (dv_cov),
      .out_q_b   (dv_q_b),
      .out_q_c   (dv_q_c),
      .out_side  (dv_side)
   );

   bcu_depth u_depth (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv_valid),
      .in_cov    (dv_cov),
      .in_q_b    (dv_q_b),
      .in_q_c    (dv_q_c),
      .in_side   (dv_side),
      .out_valid (rsp_chan.valid),
      .out_data  (rsp_chan.data)
   );

endmodule

### src/bcu_checker.sv
// port-level checks for the coverage unit, bound to the top level
module bcu_checker import bcu_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_uncovered_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.covered) |-> (rsp_data.weight_a == '0 &&
         rsp_data.weight_b == '0 && rsp_data.weight_c == '0 && rsp_data.depth_value == '0))
      else $error("uncovered item with nonzero weights or depth");

   a_weights_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.covered) |->
         ((WT_W+2)'(rsp_data.weight_a) + (WT_W+2)'(rsp_data.weight_b) +
          (WT_W+2)'(rsp_data.weight_c) == (WT_W+2)'(WEIGHT_ONE)))
      else $error("covered item weights do not sum to one");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while the response stage is stalled");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind triangle_pixel_coverage_barycentric_unit bcu_checker u_bcu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
